>>> hdl/sre_pkg.sv
// ---------------------------------------------------------------------------
// sre_pkg
// Shared types, constants and the ramp weight polynomial of the switch
// ramp envelope.
// ---------------------------------------------------------------------------
package sre_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int COUNT_BITS = 16;
  localparam int STEP_BITS  = 17;
  localparam int PHASE_BITS = 17;

  localparam logic [PHASE_BITS-1:0] PHASE_FULL = 17'd65536;

  // weights are Q0.15, 0..32768
  localparam int                    WEIGHT_BITS = 16;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE  = 16'd32768;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ZERO = 16'd0;
  localparam int                    WEIGHT_FRAC = 15;
  localparam int                    ROUND_HALF  = 16384;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 17;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_LENGTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEADY_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_LENGTH   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_STEP     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_STEP     = 3'd4;

  localparam logic [COUNT_BITS-1:0] FALL_LENGTH_RST   = 16'd240;
  localparam logic [COUNT_BITS-1:0] STEADY_LENGTH_RST = 16'd2400;
  localparam logic [COUNT_BITS-1:0] RISE_LENGTH_RST   = 16'd240;
  localparam logic [STEP_BITS-1:0]  FALL_STEP_RST     = 17'd273;
  localparam logic [STEP_BITS-1:0]  RISE_STEP_RST     = 17'd273;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  typedef enum logic [1:0] {
    STAGE_PASS   = 2'd0,
    STAGE_FALL   = 2'd1,
    STAGE_STEADY = 2'd2,
    STAGE_RISE   = 2'd3
  } stage_t;

  // odd polynomial sine, x in Q30 over 0..1 of a quarter period
  function automatic logic [WEIGHT_BITS-1:0] ramp_weight(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] w;
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995    - ((x2 * p) >> 30);
    p  = 64'd85569306   - ((x2 * p) >> 30);
    p  = 64'd693598668  - ((x2 * p) >> 30);
    p  = 64'd1686629714 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    w  = (s + 64'd16384) >> 15;
    if (w > 64'd32768) begin
      w = 64'd32768;
    end
    return w[WEIGHT_BITS-1:0];
  endfunction

endpackage

>>> hdl/sre_sample_if.sv
// ---------------------------------------------------------------------------
// sre_sample_if
// Input channel: opcode and four audio samples per beat.
// ---------------------------------------------------------------------------
interface sre_sample_if #(
  parameter int SampleBits = sre_pkg::SAMPLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [SampleBits-1:0] main_left;
  logic signed [SampleBits-1:0] main_right;
  logic signed [SampleBits-1:0] aux_left;
  logic signed [SampleBits-1:0] aux_right;

  modport source (output valid, opcode, main_left, main_right, aux_left, aux_right,
                  input ready);
  modport sink   (input valid, opcode, main_left, main_right, aux_left, aux_right,
                  output ready);
endinterface

>>> hdl/sre_result_if.sv
// ---------------------------------------------------------------------------
// sre_result_if
// Output channel: four weighted samples, applied stage and done flag.
// ---------------------------------------------------------------------------
interface sre_result_if #(
  parameter int SampleBits = sre_pkg::SAMPLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] out_main_left;
  logic signed [SampleBits-1:0] out_main_right;
  logic signed [SampleBits-1:0] out_aux_left;
  logic signed [SampleBits-1:0] out_aux_right;
  logic [1:0]                   stage_now;
  logic                         switch_done;

  modport source (output valid, out_main_left, out_main_right, out_aux_left,
                  out_aux_right, stage_now, switch_done, input ready);
  modport sink   (input valid, out_main_left, out_main_right, out_aux_left,
                  out_aux_right, stage_now, switch_done, output ready);
endinterface

>>> hdl/sre_cfg_if.sv
// ---------------------------------------------------------------------------
// sre_cfg_if
// Register write channel: index and data per beat.
// ---------------------------------------------------------------------------
interface sre_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sre_pkg::CFG_INDEX_BITS-1:0] index;
  logic [sre_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/sre_ramp_rom.sv
// ---------------------------------------------------------------------------
// sre_ramp_rom
// Quarter-sine weight table, built at elaboration, read combinationally.
// ---------------------------------------------------------------------------
module sre_ramp_rom #(
  parameter int SineTableDepth = sre_pkg::SINE_TABLE_DEPTH
) (
  input  logic [$clog2(SineTableDepth+1)-1:0] k,
  output logic [sre_pkg::WEIGHT_BITS-1:0]     weight
);

  localparam int IdxBits = $clog2(SineTableDepth + 1);
  localparam logic [IdxBits-1:0] LastEntry = IdxBits'(SineTableDepth);

  logic [sre_pkg::WEIGHT_BITS-1:0] entries [0:SineTableDepth];
  logic [IdxBits-1:0]              k_clamped;

  for (genvar g = 0; g <= SineTableDepth; g++) begin : g_entry
    localparam logic [63:0] XQ = (64'(g) << 30) / SineTableDepth;
    assign entries[g] = sre_pkg::ramp_weight(XQ);
  end

  assign k_clamped = (k > LastEntry) ? LastEntry : k;
  assign weight    = entries[k_clamped];

endmodule

>>> hdl/sre_scale.sv
// ---------------------------------------------------------------------------
// sre_scale
// One lane: Q1.15 sample times Q0.15 weight, rounded half up.
// ---------------------------------------------------------------------------
module sre_scale #(
  parameter int SampleBits = sre_pkg::SAMPLE_BITS
) (
  input  logic signed [SampleBits-1:0]      sample,
  input  logic [sre_pkg::WEIGHT_BITS-1:0]   weight,
  output logic signed [SampleBits-1:0]      scaled
);

  localparam int ProdBits = SampleBits + sre_pkg::WEIGHT_BITS + 1;

  logic signed [sre_pkg::WEIGHT_BITS:0] weight_s;
  logic signed [ProdBits-1:0]           product;
  logic signed [ProdBits-1:0]           rounded;

  assign weight_s = $signed({1'b0, weight});
  assign product  = ProdBits'(sample) * ProdBits'(weight_s);
  assign rounded  = product + ProdBits'(sre_pkg::ROUND_HALF);
  // weight never exceeds one, so the result stays in sample range
  assign scaled   = rounded[SampleBits+sre_pkg::WEIGHT_FRAC-1:sre_pkg::WEIGHT_FRAC];

endmodule

>>> hdl/switch_ramp_envelope.sv
// ---------------------------------------------------------------------------
// switch_ramp_envelope
// Switch envelope over four audio channels: fall ramp, mute, rise ramp.
// ---------------------------------------------------------------------------
// samples (sink): one beat per cycle. opcode start arms the sequence and
//   gives no result; opcode sample gives exactly one result beat.
// results (source): weighted samples, applied stage, done on last rise beat.
// cfg (sink): register writes, ready whenever out of reset; write only while idle.
// Throughput is one beat per cycle while results is not stalled; the path
//   is the phase update and table read in the first stage, then the four
//   lane multipliers feeding the result register.
// The stage, count and phase state advances as each beat is accepted; the
//   two pipeline stages advance together and hold while results is stalled,
//   and samples.ready then drops only once the output register is full.
// Reset: pass-through stage, count and phase cleared, registers at defaults,
//   pipeline emptied. No clearing pass is needed.
// ---------------------------------------------------------------------------
module switch_ramp_envelope #(
  parameter int SampleBits     = sre_pkg::SAMPLE_BITS,
  parameter int SineTableDepth = sre_pkg::SINE_TABLE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  sre_cfg_if.sink          cfg,
  sre_sample_if.sink       samples,
  sre_result_if.source     results
);

  localparam int IdxBits  = $clog2(SineTableDepth + 1);
  localparam int ScaleBits = sre_pkg::PHASE_BITS + IdxBits;
  localparam logic [IdxBits-1:0] DepthIdx = IdxBits'(SineTableDepth);

  // configuration
  logic [sre_pkg::COUNT_BITS-1:0] fall_length;
  logic [sre_pkg::COUNT_BITS-1:0] steady_length;
  logic [sre_pkg::COUNT_BITS-1:0] rise_length;
  logic [sre_pkg::STEP_BITS-1:0]  fall_step;
  logic [sre_pkg::STEP_BITS-1:0]  rise_step;

  // sequence state
  sre_pkg::stage_t                stage, stage_next;
  logic [sre_pkg::COUNT_BITS-1:0] count, count_next;
  logic [sre_pkg::PHASE_BITS-1:0] phase, phase_next;

  // first stage
  logic                           s1_valid;
  logic signed [SampleBits-1:0]   s1_ml, s1_mr, s1_al, s1_ar;
  logic [sre_pkg::WEIGHT_BITS-1:0] s1_weight;
  sre_pkg::stage_t                s1_stage;
  logic                           s1_done;

  // result register
  logic                           res_valid;
  logic signed [SampleBits-1:0]   res_ml, res_mr, res_al, res_ar;
  sre_pkg::stage_t                res_stage;
  logic                           res_done;

  logic                           advance;
  logic                           take;
  logic                           is_fall;
  logic [sre_pkg::STEP_BITS-1:0]  step;
  logic [sre_pkg::PHASE_BITS:0]   phase_sum;
  logic [sre_pkg::PHASE_BITS-1:0] phase_adv;
  logic [ScaleBits-1:0]           phase_scaled;
  logic [ScaleBits-1:0]           idx_wide;
  logic [IdxBits-1:0]             idx;
  logic [IdxBits-1:0]             rom_k;
  logic [sre_pkg::WEIGHT_BITS-1:0] rom_weight;
  logic [sre_pkg::WEIGHT_BITS-1:0] weight;
  logic [sre_pkg::COUNT_BITS-1:0] count_inc;
  logic                           done;
  logic signed [SampleBits-1:0]   sc_ml, sc_mr, sc_al, sc_ar;

  assign advance       = !res_valid || results.ready;
  assign samples.ready = advance && !rst;
  assign take          = samples.valid && samples.ready;
  assign cfg.ready     = !rst;

  // phase and ramp table index
  assign is_fall      = (stage == sre_pkg::STAGE_FALL);
  assign step         = is_fall ? fall_step : rise_step;
  assign phase_sum    = (sre_pkg::PHASE_BITS+1)'(phase) + (sre_pkg::PHASE_BITS+1)'(step);
  assign phase_adv    = (phase_sum > (sre_pkg::PHASE_BITS+1)'(sre_pkg::PHASE_FULL))
                        ? sre_pkg::PHASE_FULL : phase_sum[sre_pkg::PHASE_BITS-1:0];
  assign phase_scaled = ScaleBits'(phase_adv) * ScaleBits'(SineTableDepth);
  assign idx_wide     = phase_scaled >> 16;
  assign idx          = (idx_wide > ScaleBits'(SineTableDepth)) ? DepthIdx
                        : idx_wide[IdxBits-1:0];
  // fall reads the table backwards for the cosine
  assign rom_k        = is_fall ? (DepthIdx - idx) : idx;
  assign count_inc    = count + 1'b1;

  sre_ramp_rom #(
    .SineTableDepth (SineTableDepth)
  ) u_rom (
    .k      (rom_k),
    .weight (rom_weight)
  );

  always_comb begin
    stage_next = stage;
    count_next = count;
    phase_next = phase;
    weight     = sre_pkg::WEIGHT_ONE;
    done       = 1'b0;
    if (samples.opcode == sre_pkg::OP_START) begin
      stage_next = sre_pkg::STAGE_FALL;
      count_next = '0;
      phase_next = '0;
    end else begin
      case (stage)
        sre_pkg::STAGE_PASS: begin
          weight = sre_pkg::WEIGHT_ONE;
        end
        sre_pkg::STAGE_STEADY: begin
          weight     = sre_pkg::WEIGHT_ZERO;
          count_next = count_inc;
          if (count_inc >= steady_length) begin
            stage_next = sre_pkg::STAGE_RISE;
            count_next = '0;
            phase_next = '0;
          end
        end
        sre_pkg::STAGE_FALL: begin
          weight     = rom_weight;
          count_next = count_inc;
          phase_next = phase_adv;
          if (count_inc >= fall_length) begin
            stage_next = sre_pkg::STAGE_STEADY;
            count_next = '0;
            phase_next = '0;
          end
        end
        sre_pkg::STAGE_RISE: begin
          weight     = rom_weight;
          count_next = count_inc;
          phase_next = phase_adv;
          if (count_inc >= rise_length) begin
            stage_next = sre_pkg::STAGE_PASS;
            count_next = '0;
            phase_next = '0;
            done       = 1'b1;
          end
        end
        default: begin
          weight = sre_pkg::WEIGHT_ONE;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fall_length   <= sre_pkg::FALL_LENGTH_RST;
      steady_length <= sre_pkg::STEADY_LENGTH_RST;
      rise_length   <= sre_pkg::RISE_LENGTH_RST;
      fall_step     <= sre_pkg::FALL_STEP_RST;
      rise_step     <= sre_pkg::RISE_STEP_RST;
      stage         <= sre_pkg::STAGE_PASS;
      count         <= '0;
      phase         <= '0;
      s1_valid      <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          sre_pkg::REG_FALL_LENGTH:   fall_length   <= cfg.data[sre_pkg::COUNT_BITS-1:0];
          sre_pkg::REG_STEADY_LENGTH: steady_length <= cfg.data[sre_pkg::COUNT_BITS-1:0];
          sre_pkg::REG_RISE_LENGTH:   rise_length   <= cfg.data[sre_pkg::COUNT_BITS-1:0];
          sre_pkg::REG_FALL_STEP:     fall_step     <= cfg.data[sre_pkg::STEP_BITS-1:0];
          sre_pkg::REG_RISE_STEP:     rise_step     <= cfg.data[sre_pkg::STEP_BITS-1:0];
          default: ;
        endcase
      end
      if (take) begin
        stage <= stage_next;
        count <= count_next;
        phase <= phase_next;
      end
      if (advance) begin
        // start beats leave a bubble
        s1_valid  <= take && (samples.opcode == sre_pkg::OP_SAMPLE);
        res_valid <= s1_valid;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ml     <= samples.main_left;
      s1_mr     <= samples.main_right;
      s1_al     <= samples.aux_left;
      s1_ar     <= samples.aux_right;
      s1_weight <= weight;
      s1_stage  <= stage;
      s1_done   <= done;
      res_ml    <= sc_ml;
      res_mr    <= sc_mr;
      res_al    <= sc_al;
      res_ar    <= sc_ar;
      res_stage <= s1_stage;
      res_done  <= s1_done;
    end
  end

  sre_scale #(.SampleBits(SampleBits)) u_scale_ml (
    .sample (s1_ml), .weight (s1_weight), .scaled (sc_ml)
  );
  sre_scale #(.SampleBits(SampleBits)) u_scale_mr (
    .sample (s1_mr), .weight (s1_weight), .scaled (sc_mr)
  );
  sre_scale #(.SampleBits(SampleBits)) u_scale_al (
    .sample (s1_al), .weight (s1_weight), .scaled (sc_al)
  );
  sre_scale #(.SampleBits(SampleBits)) u_scale_ar (
    .sample (s1_ar), .weight (s1_weight), .scaled (sc_ar)
  );

  assign results.valid          = res_valid;
  assign results.out_main_left  = res_ml;
  assign results.out_main_right = res_mr;
  assign results.out_aux_left   = res_al;
  assign results.out_aux_right  = res_ar;
  assign results.stage_now      = res_stage;
  assign results.switch_done    = res_done;

endmodule

>>> test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the switch ramp envelope. A short scripted run
// covers pass-through extremes, restarts, zero lengths and steps, phase
// saturation and ignored register writes. Random sequences follow, under
// several register settings, with bursty gaps on the sample side and
// stalls on the result side. A final run stepping one table entry per
// sample sweeps the whole ramp table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam logic [sre_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [sre_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 60;
  localparam int TABLE_STEP       = 65536 / sre_pkg::SINE_TABLE_DEPTH;

  typedef struct packed {
    logic                                   opcode;
    logic signed [sre_pkg::SAMPLE_BITS-1:0] main_left;
    logic signed [sre_pkg::SAMPLE_BITS-1:0] main_right;
    logic signed [sre_pkg::SAMPLE_BITS-1:0] aux_left;
    logic signed [sre_pkg::SAMPLE_BITS-1:0] aux_right;
  } frame_beat_t;

  typedef struct packed {
    logic signed [sre_pkg::SAMPLE_BITS-1:0] main_left;
    logic signed [sre_pkg::SAMPLE_BITS-1:0] main_right;
    logic signed [sre_pkg::SAMPLE_BITS-1:0] aux_left;
    logic signed [sre_pkg::SAMPLE_BITS-1:0] aux_right;
    sre_pkg::stage_t                        stage;
    logic                                   done;
  } envelope_out_t;

  typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [sre_pkg::CFG_INDEX_BITS-1:0] index;
    logic [sre_pkg::CFG_DATA_BITS-1:0]  data;
    frame_beat_t                        beat;
    logic                               typed;
    envelope_out_t                      want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  sre_cfg_if    cfg_bus ();
  sre_sample_if sample_bus ();
  sre_result_if result_bus ();

  switch_ramp_envelope i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (sample_bus),
    .results (result_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("TEST FAILED");
    $finish;
  end

  // envelope state as the block should hold it
  sre_pkg::stage_t                 env_stage;
  logic [sre_pkg::COUNT_BITS-1:0]  env_count;
  logic [sre_pkg::PHASE_BITS-1:0]  env_phase;
  logic [sre_pkg::COUNT_BITS-1:0]  len_fall, len_steady, len_rise;
  logic [sre_pkg::STEP_BITS-1:0]   incr_fall, incr_rise;
  logic [sre_pkg::WEIGHT_BITS-1:0] ramp_table [0:sre_pkg::SINE_TABLE_DEPTH];

  envelope_out_t awaited_frames [$];
  script_row_t   script [$];

  int mismatch_count = 0;
  int frames_sent    = 0;
  int starts_sent    = 0;
  int writes_done    = 0;
  int frames_checked = 0;
  int done_seen      = 0;
  int gap_pct        = 0;
  int stall_pct      = 0;

  // Q0.15 quarter-sine weight for table entry k, polynomial in Q30
  function automatic logic [sre_pkg::WEIGHT_BITS-1:0] quarter_sine(input int unsigned k);
    longint unsigned x, x2, p, s, w;
    x  = (64'(k) << 30) / 64'(sre_pkg::SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995 - ((x2 * p) >> 30);
    p  = 64'd85569306 - ((x2 * p) >> 30);
    p  = 64'd693598668 - ((x2 * p) >> 30);
    p  = 64'd1686629714 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    w  = (s + 64'd16384) >> 15;
    if (w > 64'd32768) begin
      w = 64'd32768;
    end
    return w[sre_pkg::WEIGHT_BITS-1:0];
  endfunction

  // round half up, floor division by 2^15
  function automatic logic signed [sre_pkg::SAMPLE_BITS-1:0] scale_sample(
      input logic signed [sre_pkg::SAMPLE_BITS-1:0] v,
      input logic [sre_pkg::WEIGHT_BITS-1:0] w);
    longint prod;
    longint q;
    prod = longint'(v) * longint'(w) + 64'sd16384;
    q    = prod >>> 15;
    return q[sre_pkg::SAMPLE_BITS-1:0];
  endfunction

  function automatic void reset_envelope();
    env_stage  = sre_pkg::STAGE_PASS;
    env_count  = '0;
    env_phase  = '0;
    len_fall   = sre_pkg::FALL_LENGTH_RST;
    len_steady = sre_pkg::STEADY_LENGTH_RST;
    len_rise   = sre_pkg::RISE_LENGTH_RST;
    incr_fall  = sre_pkg::FALL_STEP_RST;
    incr_rise  = sre_pkg::RISE_STEP_RST;
  endfunction

  function automatic void apply_write(input logic [sre_pkg::CFG_INDEX_BITS-1:0] idx,
                                      input logic [sre_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      sre_pkg::REG_FALL_LENGTH:   len_fall   = data[sre_pkg::COUNT_BITS-1:0];
      sre_pkg::REG_STEADY_LENGTH: len_steady = data[sre_pkg::COUNT_BITS-1:0];
      sre_pkg::REG_RISE_LENGTH:   len_rise   = data[sre_pkg::COUNT_BITS-1:0];
      sre_pkg::REG_FALL_STEP:     incr_fall  = data[sre_pkg::STEP_BITS-1:0];
      sre_pkg::REG_RISE_STEP:     incr_rise  = data[sre_pkg::STEP_BITS-1:0];
      default: ;
    endcase
  endfunction

  // advances the envelope by one beat; returns 1 when the beat gives a result
  function automatic bit envelope_step(input frame_beat_t b, output envelope_out_t r);
    logic [sre_pkg::PHASE_BITS:0]    sum;
    longint unsigned                 idx;
    logic [sre_pkg::WEIGHT_BITS-1:0] w;
    bit                              is_fall;
    r = '0;
    r.stage = env_stage;
    r.done  = 1'b0;
    if (b.opcode == sre_pkg::OP_START) begin
      env_stage = sre_pkg::STAGE_FALL;
      env_count = '0;
      env_phase = '0;
      return 1'b0;
    end
    case (env_stage)
      sre_pkg::STAGE_PASS: begin
        r.main_left  = b.main_left;
        r.main_right = b.main_right;
        r.aux_left   = b.aux_left;
        r.aux_right  = b.aux_right;
      end
      sre_pkg::STAGE_STEADY: begin
        r.main_left  = '0;
        r.main_right = '0;
        r.aux_left   = '0;
        r.aux_right  = '0;
        env_count = env_count + 1'b1;
        if (env_count >= len_steady) begin
          env_stage = sre_pkg::STAGE_RISE;
          env_count = '0;
          env_phase = '0;
        end
      end
      default: begin
        is_fall = (env_stage == sre_pkg::STAGE_FALL);
        sum = {1'b0, env_phase} + (is_fall ? incr_fall : incr_rise);
        env_phase = (sum > sre_pkg::PHASE_FULL) ? sre_pkg::PHASE_FULL
                                                : sum[sre_pkg::PHASE_BITS-1:0];
        idx = (64'(env_phase) * 64'(sre_pkg::SINE_TABLE_DEPTH)) >> 16;
        if (idx > 64'(sre_pkg::SINE_TABLE_DEPTH)) begin
          idx = 64'(sre_pkg::SINE_TABLE_DEPTH);
        end
        // fall reads the table backwards for the cosine
        w = is_fall ? ramp_table[64'(sre_pkg::SINE_TABLE_DEPTH) - idx] : ramp_table[idx];
        r.main_left  = scale_sample(b.main_left, w);
        r.main_right = scale_sample(b.main_right, w);
        r.aux_left   = scale_sample(b.aux_left, w);
        r.aux_right  = scale_sample(b.aux_right, w);
        env_count = env_count + 1'b1;
        if (is_fall) begin
          if (env_count >= len_fall) begin
            env_stage = sre_pkg::STAGE_STEADY;
            env_count = '0;
            env_phase = '0;
          end
        end else if (env_count >= len_rise) begin
          env_stage = sre_pkg::STAGE_PASS;
          env_count = '0;
          env_phase = '0;
          r.done    = 1'b1;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic frame_beat_t make_beat(input logic op, input int ml, input int mr,
                                            input int al, input int ar);
    frame_beat_t b;
    b.opcode     = op;
    b.main_left  = ml[sre_pkg::SAMPLE_BITS-1:0];
    b.main_right = mr[sre_pkg::SAMPLE_BITS-1:0];
    b.aux_left   = al[sre_pkg::SAMPLE_BITS-1:0];
    b.aux_right  = ar[sre_pkg::SAMPLE_BITS-1:0];
    return b;
  endfunction

  function automatic void add_write(input logic [sre_pkg::CFG_INDEX_BITS-1:0] idx,
                                    input logic [sre_pkg::CFG_DATA_BITS-1:0] data);
    script_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.data  = data;
    script.push_back(row);
  endfunction

  function automatic void add_frame(input logic op, input int ml, input int mr,
                                    input int al, input int ar);
    script_row_t row;
    row      = '0;
    row.kind = ROW_FRAME;
    row.beat = make_beat(op, ml, mr, al, ar);
    script.push_back(row);
  endfunction

  // a sample row whose result is written out by hand
  function automatic void add_typed(input int ml, input int mr, input int al, input int ar,
                                    input int oml, input int omr, input int oal,
                                    input int oar, input sre_pkg::stage_t st,
                                    input logic dn);
    script_row_t row;
    row                 = '0;
    row.kind            = ROW_FRAME;
    row.beat            = make_beat(sre_pkg::OP_SAMPLE, ml, mr, al, ar);
    row.typed           = 1'b1;
    row.want.main_left  = oml[sre_pkg::SAMPLE_BITS-1:0];
    row.want.main_right = omr[sre_pkg::SAMPLE_BITS-1:0];
    row.want.aux_left   = oal[sre_pkg::SAMPLE_BITS-1:0];
    row.want.aux_right  = oar[sre_pkg::SAMPLE_BITS-1:0];
    row.want.stage      = st;
    row.want.done       = dn;
    script.push_back(row);
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 15))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return int'($signed(16'($urandom())));
    endcase
  endfunction

  function automatic logic [sre_pkg::CFG_DATA_BITS-1:0] rand_length();
    logic [sre_pkg::CFG_DATA_BITS-1:0] d;
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = 17'd1;
      default: d = 17'($urandom_range(2, 12));
    endcase
    // bit 16 lies outside the length register
    d[16] = $urandom_range(0, 1);
    return d;
  endfunction

  function automatic logic [sre_pkg::CFG_DATA_BITS-1:0] rand_incr();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd65536;
      3: return 17'($urandom_range(65537, 131071));
      4: return 17'd131071;
      default: return 17'($urandom_range(2000, 40000));
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 25;
      default: return 50;
    endcase
  endfunction

  task automatic drive_beat(input frame_beat_t b, input logic typed,
                            input envelope_out_t want);
    envelope_out_t r;
    bit            has_result;
    int            gap;
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 5);
      sample_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_bus.valid      <= 1'b1;
    sample_bus.opcode     <= b.opcode;
    sample_bus.main_left  <= b.main_left;
    sample_bus.main_right <= b.main_right;
    sample_bus.aux_left   <= b.aux_left;
    sample_bus.aux_right  <= b.aux_right;
    @(posedge clk);
    while (sample_bus.ready !== 1'b1) @(posedge clk);
    has_result = envelope_step(b, r);
    if (has_result) begin
      awaited_frames.push_back(typed ? want : r);
      frames_sent++;
    end else begin
      starts_sent++;
    end
  endtask

  // registers change only once the pipeline has drained
  task automatic write_register(input logic [sre_pkg::CFG_INDEX_BITS-1:0] idx,
                                input logic [sre_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    while (awaited_frames.size() != 0) @(negedge clk);
    // a start beat leaves nothing awaited, so let it settle too
    repeat (4) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (cfg_bus.ready !== 1'b1) @(posedge clk);
    apply_write(idx, data);
    writes_done++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
               $signed(want), $signed(got));
    end
  endfunction

  // result stalls come in random bursts, at the rate set by stall_pct
  initial begin
    int hold;
    hold = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        result_bus.ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(0, 4);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    envelope_out_t want;
    if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (awaited_frames.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat with nothing awaited, expected none actual %0d",
                 $time, $signed(result_bus.out_main_left));
      end else begin
        want = awaited_frames.pop_front();
        frames_checked++;
        compare_field("out_main_left", want.main_left, result_bus.out_main_left);
        compare_field("out_main_right", want.main_right, result_bus.out_main_right);
        compare_field("out_aux_left", want.aux_left, result_bus.out_aux_left);
        compare_field("out_aux_right", want.aux_right, result_bus.out_aux_right);
        compare_field("stage_now", 16'(want.stage), 16'(result_bus.stage_now));
        compare_field("switch_done", 16'(want.done), 16'(result_bus.switch_done));
        if (result_bus.switch_done === 1'b1) begin
          done_seen++;
        end
      end
    end
  end

  initial begin
    frame_beat_t   b;
    envelope_out_t none;
    logic          op;
    int            drain;
    none = '0;
    rst = 1'b1;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    sample_bus.valid      = 1'b0;
    sample_bus.opcode     = sre_pkg::OP_SAMPLE;
    sample_bus.main_left  = '0;
    sample_bus.main_right = '0;
    sample_bus.aux_left   = '0;
    sample_bus.aux_right  = '0;

    for (int k = 0; k <= sre_pkg::SINE_TABLE_DEPTH; k++) begin
      ramp_table[k] = quarter_sine(k);
    end
    reset_envelope();

    // pass-through out of reset, restarts, zero lengths and steps, saturation
    add_typed(32767, -32768, 0, -1, 32767, -32768, 0, -1, sre_pkg::STAGE_PASS, 1'b0);
    add_typed(-32768, 32767, 1, 23130, -32768, 32767, 1, 23130, sre_pkg::STAGE_PASS,
              1'b0);
    add_frame(sre_pkg::OP_START, 0, 0, 0, 0);
    add_frame(sre_pkg::OP_SAMPLE, 32767, -32768, 12345, -1);
    add_frame(sre_pkg::OP_START, 0, 0, 0, 0);
    add_frame(sre_pkg::OP_SAMPLE, -32768, 32767, -12345, 1);
    add_write(sre_pkg::REG_FALL_LENGTH, 17'd2);
    add_frame(sre_pkg::OP_SAMPLE, 20000, -20000, 32767, -32768);
    add_write(sre_pkg::REG_STEADY_LENGTH, 17'd0);
    add_typed(32767, -32768, 5, -5, 0, 0, 0, 0, sre_pkg::STAGE_STEADY, 1'b0);
    add_frame(sre_pkg::OP_SAMPLE, 32767, -32768, 100, -100);
    add_write(sre_pkg::REG_RISE_LENGTH, 17'd2);
    add_frame(sre_pkg::OP_SAMPLE, -32768, 32767, -1, 1);
    add_typed(-1, 1, -32768, 32767, -1, 1, -32768, 32767, sre_pkg::STAGE_PASS, 1'b0);
    add_write(sre_pkg::REG_FALL_STEP, 17'd65536);
    add_write(sre_pkg::REG_RISE_STEP, 17'd131071);
    add_write(REG_SPARE_LO, 17'h1ffff);
    add_write(REG_SPARE_HI, 17'd0);
    add_frame(sre_pkg::OP_START, 0, 0, 0, 0);
    add_typed(32767, -32768, 32767, -32768, 0, 0, 0, 0, sre_pkg::STAGE_FALL, 1'b0);
    add_frame(sre_pkg::OP_SAMPLE, 1234, -4321, 32767, -32768);
    add_typed(-7, 7, 32767, -32768, 0, 0, 0, 0, sre_pkg::STAGE_STEADY, 1'b0);
    add_frame(sre_pkg::OP_SAMPLE, 32767, -32768, 32767, -32768);
    add_frame(sre_pkg::OP_SAMPLE, -32768, 32767, -32768, 32767);
    add_write(sre_pkg::REG_FALL_STEP, 17'd0);
    add_write(sre_pkg::REG_RISE_LENGTH, 17'd1);
    add_frame(sre_pkg::OP_START, 0, 0, 0, 0);
    add_frame(sre_pkg::OP_SAMPLE, 32767, -32768, 32767, -32768);
    add_frame(sre_pkg::OP_SAMPLE, -32768, 32767, 1, -1);
    add_typed(9, 9, 9, 9, 0, 0, 0, 0, sre_pkg::STAGE_STEADY, 1'b0);
    add_frame(sre_pkg::OP_SAMPLE, 32767, -32768, 16384, -16384);
    add_typed(111, -222, 333, -444, 111, -222, 333, -444, sre_pkg::STAGE_PASS, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_pct   = 30;
    stall_pct = 30;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_register(script[i].index, script[i].data);
      end else begin
        drive_beat(script[i].beat, script[i].typed, script[i].want);
      end
    end

    // random sequences, the envelope state steers towards well-formed runs
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gap_pct   = pick_idle_pct();
      stall_pct = pick_idle_pct();
      write_register(sre_pkg::REG_FALL_LENGTH, rand_length());
      write_register(sre_pkg::REG_STEADY_LENGTH, rand_length());
      write_register(sre_pkg::REG_RISE_LENGTH, rand_length());
      write_register(sre_pkg::REG_FALL_STEP, rand_incr());
      write_register(sre_pkg::REG_RISE_STEP, rand_incr());
      if ($urandom_range(0, 2) == 0) begin
        write_register(sre_pkg::CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                       17'($urandom_range(0, 131071)));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (env_stage == sre_pkg::STAGE_PASS) begin
          op = ($urandom_range(0, 9) < 6) ? sre_pkg::OP_START : sre_pkg::OP_SAMPLE;
        end else begin
          op = ($urandom_range(0, 49) == 0) ? sre_pkg::OP_START : sre_pkg::OP_SAMPLE;
        end
        b = make_beat(op, rand_sample(), rand_sample(), rand_sample(), rand_sample());
        drive_beat(b, 1'b0, none);
      end
    end

    // one table entry per sample over both ramps, no idling from here on
    gap_pct   = 0;
    stall_pct = 0;
    write_register(sre_pkg::REG_FALL_LENGTH,
                   sre_pkg::CFG_DATA_BITS'(sre_pkg::SINE_TABLE_DEPTH));
    write_register(sre_pkg::REG_STEADY_LENGTH, 17'd4);
    write_register(sre_pkg::REG_RISE_LENGTH,
                   sre_pkg::CFG_DATA_BITS'(sre_pkg::SINE_TABLE_DEPTH));
    write_register(sre_pkg::REG_FALL_STEP, sre_pkg::CFG_DATA_BITS'(TABLE_STEP));
    write_register(sre_pkg::REG_RISE_STEP, sre_pkg::CFG_DATA_BITS'(TABLE_STEP));
    drive_beat(make_beat(sre_pkg::OP_START, 0, 0, 0, 0), 1'b0, none);
    while (env_stage != sre_pkg::STAGE_PASS) begin
      b = make_beat(sre_pkg::OP_SAMPLE, rand_sample(), rand_sample(), rand_sample(),
                    rand_sample());
      drive_beat(b, 1'b0, none);
    end
    drive_beat(make_beat(sre_pkg::OP_SAMPLE, rand_sample(), 0, 0, 0), 1'b0, none);

    @(negedge clk);
    sample_bus.valid <= 1'b0;
    drain = 0;
    while (awaited_frames.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    if (awaited_frames.size() != 0) begin
      mismatch_count++;
      $display("%0t: result beats missing, expected %0d more actual 0", $time,
               awaited_frames.size());
    end
    repeat (10) @(posedge clk);

    $display("covered %0d sample beats and %0d start beats over %0d register writes",
             frames_sent, starts_sent, writes_done);
    $display("checked %0d result beats, %0d sequences ran to completion, %0d mismatches",
             frames_checked, done_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
